>>> design/hexdec_pkg.sv
// Shared types, constants and helpers for the ASCII hex line decoder.
// No dependencies; used by hexdec_store, hexdec_ctrl and the top level.
`default_nettype none

package hexdec_pkg;

  // Default line buffer sizing; the store holds ReqSizeDefault-1 characters
  localparam int unsigned ReqSizeDefault = 64;

  // Most results a single frame may produce
  localparam int unsigned MaxResults = 32;
  localparam int unsigned ResW       = $clog2(MaxResults + 1);

  // Character codes
  localparam logic [7:0] ChrCr    = 8'h0d;
  localparam logic [7:0] ChrLf    = 8'h0a;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpF   = 8'h46;
  localparam logic [7:0] ChrLoA   = 8'h61;
  localparam logic [7:0] ChrLoF   = 8'h66;
  localparam logic [3:0] NibTen   = 4'd10;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StProc,
    StEnd
  } state_e;

  // Access request from the sequencer to the line store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_req_t;

  // Decoded hex digit: bad set when the character is not a hex digit
  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    logic [7:0] diff;
    n    = '{bad: 1'b1, value: 4'd0};
    diff = 8'd0;
    if (c >= ChrZero && c <= ChrNine) begin
      diff = c - ChrZero;
      n    = '{bad: 1'b0, value: diff[3:0]};
    end else if (c >= ChrUpA && c <= ChrUpF) begin
      diff = c - ChrUpA;
      n    = '{bad: 1'b0, value: diff[3:0] + NibTen};
    end else if (c >= ChrLoA && c <= ChrLoF) begin
      diff = c - ChrLoA;
      n    = '{bad: 1'b0, value: diff[3:0] + NibTen};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/hexdec_store.sv
// Line store: simple dual-port style character memory, one write and one read
// per cycle, read data registered. Uses hexdec_pkg::mem_req_t.
`default_nettype none

module hexdec_store #(
  parameter int unsigned Depth = hexdec_pkg::ReqSizeDefault - 1,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire hexdec_pkg::mem_req_t req_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire logic [7:0]           wr_data_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output logic      [7:0]           rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // Write the arriving character
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> design/hexdec_ctrl.sv
// Sequencer: collects characters, walks the line store on a terminator
// (check, then emit if the line is clean), and drives the result register.
// Uses hexdec_pkg for states, codes and the hex digit decode.
`default_nettype none

module hexdec_ctrl #(
  parameter int unsigned ReqSize = hexdec_pkg::ReqSizeDefault,
  parameter int unsigned Depth   = ReqSize - 1,
  parameter int unsigned AddrW   = $clog2(Depth),
  parameter int unsigned CntW    = $clog2(ReqSize)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rx_valid_i,
  output logic                      rx_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      tx_valid_o,
  input  wire logic                 tx_ready_i,
  output logic                      is_error_o,
  output logic      [7:0]           data_byte_o,
  output logic                      last_o,
  output hexdec_pkg::mem_req_t      mem_req_o,
  output logic      [AddrW-1:0]     wr_addr_o,
  output logic      [7:0]           wr_data_o,
  output logic      [AddrW-1:0]     rd_addr_o,
  input  wire logic [7:0]           rd_data_i
);

  localparam int unsigned ResW = hexdec_pkg::ResW;

  hexdec_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            pass_q, pass_d;      // 0: check pass, 1: emit pass
  logic            have_hi_q, have_hi_d;
  logic [7:0]      hi_q, hi_d;
  logic            bad_q, bad_d;
  logic [ResW-1:0] total_q, total_d;
  logic [ResW-1:0] emit_q, emit_d;
  logic            tx_valid_q, tx_valid_d;
  logic            is_error_q, is_error_d;
  logic [7:0]      data_q, data_d;
  logic            last_q, last_d;

  logic                rx_fire;
  logic                tx_free;
  logic                is_term;
  hexdec_pkg::nibble_t nib_hi, nib_lo;
  logic [ResW-1:0]     emit_next;

  assign rx_fire   = rx_valid_i && rx_ready_o;
  assign tx_free   = !tx_valid_q || tx_ready_i;
  assign is_term   = (rx_byte_i == hexdec_pkg::ChrCr) || (rx_byte_i == hexdec_pkg::ChrLf);
  assign nib_hi    = hexdec_pkg::hex_nibble(hi_q);
  assign nib_lo    = hexdec_pkg::hex_nibble(rd_data_i);
  assign emit_next = emit_q + 1'b1;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hexdec_pkg::StIdle;
      count_q    <= '0;
      tx_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      tx_valid_q <= tx_valid_d;
    end
  end

  // Walk and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pass_q     <= pass_d;
    have_hi_q  <= have_hi_d;
    hi_q       <= hi_d;
    bad_q      <= bad_d;
    total_q    <= total_d;
    emit_q     <= emit_d;
    is_error_q <= is_error_d;
    data_q     <= data_d;
    last_q     <= last_d;
  end

  // Next state, memory requests and result loading
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    have_hi_d  = have_hi_q;
    hi_d       = hi_q;
    bad_d      = bad_q;
    total_d    = total_q;
    emit_d     = emit_q;
    is_error_d = is_error_q;
    data_d     = data_q;
    last_d     = last_q;
    tx_valid_d = tx_valid_q && !tx_ready_i;
    rx_ready_o = 1'b0;
    mem_req_o  = '{wr_en: 1'b0, rd_en: 1'b0};
    wr_addr_o  = count_q[AddrW-1:0];
    wr_data_o  = rx_byte_i;
    rd_addr_o  = idx_q[AddrW-1:0];

    unique case (state_q)
      hexdec_pkg::StIdle: begin
        rx_ready_o = 1'b1;
        if (rx_fire) begin
          if (is_term) begin
            // Start the check pass on a non-empty line
            if (count_q != '0) begin
              idx_d     = '0;
              pass_d    = 1'b0;
              have_hi_d = 1'b0;
              bad_d     = 1'b0;
              total_d   = '0;
              state_d   = hexdec_pkg::StRead;
            end
          end else if (rx_byte_i >= hexdec_pkg::ChrSpace) begin
            // Append, or drop the whole line when the store is full
            if (count_q < CntW'(Depth)) begin
              mem_req_o.wr_en = 1'b1;
              count_d         = count_q + 1'b1;
            end else begin
              count_d = '0;
            end
          end
        end
      end

      hexdec_pkg::StRead: begin
        if (idx_q == count_q) begin
          state_d = hexdec_pkg::StEnd;
        end else begin
          mem_req_o.rd_en = 1'b1;
          state_d         = hexdec_pkg::StProc;
        end
      end

      hexdec_pkg::StProc: begin
        if (!have_hi_q) begin
          // Skip spaces; otherwise hold the high digit
          if (rd_data_i != hexdec_pkg::ChrSpace) begin
            hi_d      = rd_data_i;
            have_hi_d = 1'b1;
          end
          idx_d   = idx_q + 1'b1;
          state_d = hexdec_pkg::StRead;
        end else if (!pass_q) begin
          if (nib_hi.bad || nib_lo.bad) begin
            bad_d   = 1'b1;
            state_d = hexdec_pkg::StEnd;
          end else begin
            if (total_q < ResW'(hexdec_pkg::MaxResults)) begin
              total_d = total_q + 1'b1;
            end
            have_hi_d = 1'b0;
            idx_d     = idx_q + 1'b1;
            state_d   = hexdec_pkg::StRead;
          end
        end else if (tx_free) begin
          // Emit the byte; the read data holds while the result waits
          tx_valid_d = 1'b1;
          is_error_d = 1'b0;
          data_d     = {nib_hi.value, nib_lo.value};
          last_d     = (emit_next == total_q);
          emit_d     = emit_next;
          have_hi_d  = 1'b0;
          idx_d      = idx_q + 1'b1;
          state_d    = (emit_next == total_q) ? hexdec_pkg::StEnd : hexdec_pkg::StRead;
        end
      end

      hexdec_pkg::StEnd: begin
        if (pass_q) begin
          count_d = '0;
          state_d = hexdec_pkg::StIdle;
        end else if (bad_q || total_q == '0) begin
          // Give the single error result, then empty the line
          if (tx_free) begin
            tx_valid_d = 1'b1;
            is_error_d = 1'b1;
            data_d     = 8'd0;
            last_d     = 1'b1;
            count_d    = '0;
            state_d    = hexdec_pkg::StIdle;
          end
        end else begin
          // Line is clean: walk it again and emit
          pass_d    = 1'b1;
          idx_d     = '0;
          have_hi_d = 1'b0;
          emit_d    = '0;
          state_d   = hexdec_pkg::StRead;
        end
      end

      default: begin
        state_d = hexdec_pkg::StIdle;
      end
    endcase
  end

  assign tx_valid_o  = tx_valid_q;
  assign is_error_o  = is_error_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> design/ascii_hex_line_decoder.sv
// ASCII hex line decoder. Plain characters are taken only while idle.
// A terminator walks the stored line in a check pass and, if the line is clean,
// an emit pass; each stored character is read through the registered line
// store read port (StRead, then StProc), and output stalls hold the emit pass.
// Results leave through a one-entry output register. Reset clears the
// character count and the sequencer; the line store itself is not cleared.
`default_nettype none

module ascii_hex_line_decoder #(
  parameter int unsigned ReqSize = hexdec_pkg::ReqSizeDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            tx_valid_o,
  input  wire logic       tx_ready_i,
  output logic            is_error_o,
  output logic      [7:0] data_byte_o,
  output logic            last_o
);

  localparam int unsigned Depth = ReqSize - 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(ReqSize);

  hexdec_pkg::mem_req_t mem_req;
  logic [AddrW-1:0]     wr_addr;
  logic [7:0]           wr_data;
  logic [AddrW-1:0]     rd_addr;
  logic [7:0]           rd_data;

  hexdec_ctrl #(
    .ReqSize (ReqSize),
    .Depth   (Depth),
    .AddrW   (AddrW),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .tx_valid_o  (tx_valid_o),
    .tx_ready_i  (tx_ready_i),
    .is_error_o  (is_error_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .mem_req_o   (mem_req),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  hexdec_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire
